[hw/rtl/rbwh_pkg.sv]
`default_nettype none

package rbwh_pkg;

    localparam int POS_W   = 48;
    localparam int AVAIL_W = 13;
    localparam int RES_W   = 13;
    localparam logic [RES_W-1:0] RESERVE_RST = 13'd1024;

    typedef enum logic [2:0] {
        REQ_WRITE     = 3'd0,
        REQ_READ      = 3'd1,
        REQ_SEEK      = 3'd2,
        REQ_RESET     = 3'd3,
        REQ_SET_END   = 3'd4,
        REQ_CLEAR_END = 3'd5,
        REQ_QUERY     = 3'd6
    } t_req;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_ROOM     = 3'd1,
        ST_WOULD_BLOCK = 3'd2,
        ST_END         = 3'd3,
        ST_SEEK_ERR    = 3'd4
    } t_status;

    // Item parked between the state update and the output register.
    typedef struct packed {
        t_status           status;
        logic              rd_hit;
        logic              is_query;
        logic [POS_W-1:0]  pos;
    } t_stage;

    typedef struct packed {
        t_status             status;
        logic [7:0]          read_byte;
        logic [AVAIL_W-1:0]  available;
        logic [POS_W-1:0]    end_pos;
        logic                is_cached;
        logic                input_ended;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/rbwh_ram.sv]
`default_nettype none

module rbwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ring_buffer_with_history_core.sv]
// Byte ring buffer with read-back history over absolute 48-bit stream positions.
// Input channel (i_in_valid / o_in_ready) carries one request item: write byte,
// read byte, seek, reset, set/clear end of input, or query. Output channel
// (o_out_valid / i_out_ready) returns exactly one result item per request.
// The back_reserve register is written through i_cfg_we / i_cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// Pointer state is updated at the accept edge; the byte RAM read is registered,
// so the read byte and the post-step status fields are gathered in a holding
// stage, then moved into the output register.
// Throughput: one item per cycle while the receiver takes results.
// Receiver stall: the output register holds its item and one more item may sit
// in the holding stage; after that o_in_ready drops until the output drains.
// Reset (synchronous, active low): all pointers go to 0, end of input clears,
// back_reserve returns to 1024. The byte RAM is not cleared; its contents are
// undefined until written and are only read behind the write pointer.
`default_nettype none

module ring_buffer_with_history_core
    import rbwh_pkg::*;
#(
    parameter int BUF_DEPTH = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config
    input  wire logic               i_cfg_we,
    input  wire logic [RES_W-1:0]   i_cfg_wdata,
    // request channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_req_type,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic               i_clear_anyway,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [2:0]              o_status,
    output logic [7:0]              o_read_byte,
    output logic [AVAIL_W-1:0]      o_available,
    output logic [POS_W-1:0]        o_end_pos,
    output logic                    o_is_cached,
    output logic                    o_input_ended
);

    localparam int AW = $clog2(BUF_DEPTH);
    // width for history/unread counts and the reserve
    localparam int CW = (AW + 1 > RES_W) ? AW + 1 : RES_W;

    // architectural state
    logic [RES_W-1:0] r_back_reserve;
    logic [POS_W-1:0] r_oldest_pos, n_oldest_pos;
    logic [POS_W-1:0] r_write_pos,  n_write_pos;
    logic [POS_W-1:0] r_read_pos,   n_read_pos;
    logic             r_ended,      n_ended;

    // pipeline
    logic    r_s2_valid;
    t_stage  r_s2, n_s2;
    logic    r_out_valid;
    t_result r_out, n_out;

    logic w_s2_go, w_acc;
    t_req w_req;

    // window / room arithmetic
    logic [POS_W-1:0] w_d_pos, w_d_wr, w_d_s2;
    logic             w_in_win, w_s2_win;
    logic [AW:0]      w_back, w_front, w_span;
    logic [CW-1:0]    w_kept;
    logic [CW:0]      w_need;
    logic             w_no_room, w_full, w_empty;

    logic             w_ram_we, w_ram_re;
    logic [7:0]       w_ram_rdata;

    // handshake: holding stage drains into the output register when it is free
    assign w_s2_go    = r_s2_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s2_valid || w_s2_go;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_req      = t_req'(i_req_type);

    // window test against oldest kept; offsets wrap mod 2^48
    assign w_d_pos  = i_position - r_oldest_pos;
    assign w_d_wr   = r_write_pos - r_oldest_pos;
    assign w_in_win = (w_d_pos <= w_d_wr);

    // spans never exceed BUF_DEPTH, so the low AW+1 bits are exact
    assign w_back  = r_read_pos[AW:0]  - r_oldest_pos[AW:0];
    assign w_front = r_write_pos[AW:0] - r_read_pos[AW:0];
    assign w_span  = r_write_pos[AW:0] - r_oldest_pos[AW:0];
    assign w_kept  = (CW'(w_back) < CW'(r_back_reserve)) ? CW'(w_back) : CW'(r_back_reserve);
    assign w_need  = (CW+1)'(w_kept) + (CW+1)'(w_front);
    assign w_no_room = (w_need >= (CW+1)'(BUF_DEPTH));
    assign w_full    = (w_span == (AW+1)'(BUF_DEPTH));
    assign w_empty   = (r_write_pos == r_read_pos);

    // request decode and pointer update, all at the accept edge
    always_comb begin
        n_oldest_pos = r_oldest_pos;
        n_write_pos  = r_write_pos;
        n_read_pos   = r_read_pos;
        n_ended      = r_ended;
        w_ram_we     = 1'b0;
        w_ram_re     = 1'b0;
        n_s2.status   = ST_OK;
        n_s2.rd_hit   = 1'b0;
        n_s2.is_query = 1'b0;
        n_s2.pos      = i_position;
        case (w_req)
            REQ_WRITE: begin
                if (w_no_room) begin
                    n_s2.status = ST_NO_ROOM;
                end else begin
                    w_ram_we    = w_acc;
                    n_write_pos = r_write_pos + POS_W'(1);
                    // store full: drop the oldest history byte
                    if (w_full) begin
                        n_oldest_pos = r_oldest_pos + POS_W'(1);
                    end
                end
            end
            REQ_READ: begin
                if (w_empty) begin
                    n_s2.status = r_ended ? ST_END : ST_WOULD_BLOCK;
                end else begin
                    w_ram_re    = w_acc;
                    n_s2.rd_hit = 1'b1;
                    n_read_pos  = r_read_pos + POS_W'(1);
                end
            end
            REQ_SEEK: begin
                if (w_in_win) begin
                    n_read_pos = i_position;
                end else begin
                    n_s2.status = ST_SEEK_ERR;
                end
            end
            REQ_RESET: begin
                if (!i_clear_anyway && w_in_win) begin
                    n_read_pos = i_position;
                end else begin
                    n_oldest_pos = i_position;
                    n_write_pos  = i_position;
                    n_read_pos   = i_position;
                end
            end
            REQ_SET_END:   n_ended = 1'b1;
            REQ_CLEAR_END: n_ended = 1'b0;
            REQ_QUERY:     n_s2.is_query = 1'b1;
            default: ;
        endcase
    end

    rbwh_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_write_pos[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_re    (w_ram_re),
        .i_raddr (r_read_pos[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Holding stage sees post-step pointers: no new item can land before it drains.
    assign w_d_s2   = r_s2.pos - r_oldest_pos;
    assign w_s2_win = (w_d_s2 <= w_d_wr);

    always_comb begin
        n_out.status      = r_s2.status;
        n_out.read_byte   = r_s2.rd_hit ? w_ram_rdata : 8'd0;
        n_out.available   = AVAIL_W'(r_write_pos - r_read_pos);
        n_out.end_pos     = (r_s2.is_query && !w_s2_win) ? r_s2.pos : r_write_pos;
        n_out.is_cached   = w_s2_win;
        n_out.input_ended = r_ended;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_reserve <= RESERVE_RST;
            r_oldest_pos   <= '0;
            r_write_pos    <= '0;
            r_read_pos     <= '0;
            r_ended        <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_back_reserve <= i_cfg_wdata;
            end
            if (w_acc) begin
                r_oldest_pos <= n_oldest_pos;
                r_write_pos  <= n_write_pos;
                r_read_pos   <= n_read_pos;
                r_ended      <= n_ended;
                r_s2_valid   <= 1'b1;
            end else if (w_s2_go) begin
                r_s2_valid <= 1'b0;
            end
            if (w_s2_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s2 <= n_s2;
        end
        if (w_s2_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_read_byte   = r_out.read_byte;
    assign o_available   = r_out.available;
    assign o_end_pos     = r_out.end_pos;
    assign o_is_cached   = r_out.is_cached;
    assign o_input_ended = r_out.input_ended;

    // kept window never exceeds the store
    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d_wr <= POS_W'(BUF_DEPTH))
        else $error("kept window larger than the store");

    // read point stays inside the kept window
    a_read_in_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_read_pos - r_oldest_pos) <= w_d_wr)
        else $error("read pointer outside kept window");

    // a parked item is not lost while the output is stalled
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_out_valid && !i_out_ready) |=> r_s2_valid)
        else $error("holding stage dropped an item");

    // store is never written and read in the same cycle
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_ram_re))
        else $error("simultaneous store write and read");

endmodule

`default_nettype wire
